// ===== src/cpp_pkg.sv =====
`default_nettype none
package cpp_pkg;

  typedef enum logic [1:0] {
    CMD_LOAD    = 2'd0,
    CMD_PROJECT = 2'd1,
    CMD_FACING  = 2'd2,
    CMD_NONE    = 2'd3
  } cmd_e;

  localparam logic KIND_PROJECT = 1'b0;
  localparam logic KIND_FACING  = 1'b1;

  // config register indexes
  localparam logic [7:0] REG_FOCAL_X  = 8'd0;
  localparam logic [7:0] REG_FOCAL_Y  = 8'd1;
  localparam logic [7:0] REG_CENTER_X = 8'd2;
  localparam logic [7:0] REG_CENTER_Y = 8'd3;

  localparam int unsigned NUM_POSE = 12;
  localparam int unsigned POS_BASE = 9;
  localparam logic [31:0] ONE_Q16 = 32'h0001_0000;

  // quotient bits kept by the divider; anything larger saturates the pixel
  localparam int unsigned DIV_STEPS = 35;

  localparam logic signed [63:0] MAX32 = 64'sh0000_0000_7fff_ffff;
  localparam logic signed [63:0] MIN32 = 64'shffff_ffff_8000_0000;

  // one classified word between front and back; d is [vertex][axis]
  typedef struct packed {
    logic             kind;
    logic [8:0][31:0] rot;
    logic [2:0][2:0][31:0] d;
  } work_t;

  typedef struct packed {
    logic        kind;
    logic [31:0] pixel_u;
    logic [31:0] pixel_v;
    logic        faces;
    logic        bad;
  } result_t;

  function automatic logic [31:0] sat32(input logic signed [63:0] v);
    if (v > MAX32) begin
      return 32'h7fff_ffff;
    end else if (v < MIN32) begin
      return 32'h8000_0000;
    end else begin
      return v[31:0];
    end
  endfunction

endpackage
`default_nettype wire

// ===== src/camera_point_projector_top.sv =====
// Pinhole camera projector with back-face test; signed Q16.16 points.
// Input channel (push/full): cmd_i selects load of one pose word (rotation
// row-major in words 0-8, position in 9-11), projection of vertex a, or a
// facing test on triangle a, b, c. Loads and unused commands give no result.
// Result channel (empty/pop): result_kind_o tells projection from facing;
// pixel_u_o/pixel_v_o are saturated pixels, depth_invalid_o flags depth <= 0.
// Config channel (cfg_valid_i/cfg_ready_o): focal lengths and principal
// point, unsigned Q16.16, indexes 0-3; always ready; write only while the
// block is idle.
// Throughput: one word per cycle sustained while results are popped. A
// word crosses 44 register stages: front register, front/back queue, six
// arithmetic stages, 35 divider stages (one quotient bit each), output queue.
// Facing results ride the same pipe so results stay in order.
// When the receiver stops popping, the output queue fills, the back pipe
// freezes, the two-word middle queue fills and full rises; no word is lost.
// Reset: identity rotation, zero position, focal 1.0, center 0, queues empty.
`default_nettype none
module camera_point_projector_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic [1:0]  cmd_i,
  input  logic [3:0]  word_index_i,
  input  logic [31:0] word_value_i,
  input  logic [31:0] ax_i,
  input  logic [31:0] ay_i,
  input  logic [31:0] az_i,
  input  logic [31:0] bx_i,
  input  logic [31:0] by_i,
  input  logic [31:0] bz_i,
  input  logic [31:0] cx_world_i,
  input  logic [31:0] cy_world_i,
  input  logic [31:0] cz_world_i,
  output logic        empty,
  input  logic        pop,
  output logic        result_kind_o,
  output logic [31:0] pixel_u_o,
  output logic [31:0] pixel_v_o,
  output logic        faces_camera_o,
  output logic        depth_invalid_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [7:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i
);
  logic [31:0] focal_x_q, focal_y_q, center_x_q, center_y_q;
  logic [2:0][2:0][31:0] world;

  cpp_pkg::work_t   front_word, back_word;
  logic             front_valid, mid_full, mid_empty, mid_pop;
  cpp_pkg::result_t res_in, res_out;
  logic             res_push, res_full;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      focal_x_q  <= cpp_pkg::ONE_Q16;
      focal_y_q  <= cpp_pkg::ONE_Q16;
      center_x_q <= 32'h0;
      center_y_q <= 32'h0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        cpp_pkg::REG_FOCAL_X:  focal_x_q  <= cfg_data_i;
        cpp_pkg::REG_FOCAL_Y:  focal_y_q  <= cfg_data_i;
        cpp_pkg::REG_CENTER_X: center_x_q <= cfg_data_i;
        cpp_pkg::REG_CENTER_Y: center_y_q <= cfg_data_i;
        default: ;  // writes past the register list are dropped
      endcase
    end
  end

  assign world = {{cz_world_i, cy_world_i, cx_world_i},
                  {bz_i, by_i, bx_i},
                  {az_i, ay_i, ax_i}};

  // front: pose store, command decode, world-minus-position
  cpp_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push         (push),
    .full         (full),
    .cmd_i        (cmd_i),
    .word_index_i (word_index_i),
    .word_value_i (word_value_i),
    .world_i      (world),
    .work_valid_o (front_valid),
    .work_o       (front_word),
    .work_full_i  (mid_full)
  );

  cpp_fifo #(.WIDTH($bits(cpp_pkg::work_t)), .DEPTH(2)) u_mid_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (front_valid),
    .data_i  (front_word),
    .full_o  (mid_full),
    .pop_i   (mid_pop),
    .data_o  (back_word),
    .empty_o (mid_empty)
  );

  // back: camera transform, determinant sign, pipelined divide
  cpp_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .work_valid_i (!mid_empty),
    .work_i       (back_word),
    .work_pop_o   (mid_pop),
    .focal_x_i    (focal_x_q),
    .focal_y_i    (focal_y_q),
    .center_x_i   (center_x_q),
    .center_y_i   (center_y_q),
    .res_valid_o  (res_push),
    .res_o        (res_in),
    .res_full_i   (res_full)
  );

  cpp_fifo #(.WIDTH($bits(cpp_pkg::result_t)), .DEPTH(2)) u_out_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .data_i  (res_in),
    .full_o  (res_full),
    .pop_i   (pop),
    .data_o  (res_out),
    .empty_o (empty)
  );

  assign result_kind_o   = res_out.kind;
  assign pixel_u_o       = res_out.pixel_u;
  assign pixel_v_o       = res_out.pixel_v;
  assign faces_camera_o  = res_out.faces;
  assign depth_invalid_o = res_out.bad;

endmodule
`default_nettype wire

// ===== src/cpp_fifo.sv =====
`default_nettype none
module cpp_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] data_o,
  output logic             empty_o
);
  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PW-1:0] wptr_q, wptr_d, rptr_q, rptr_d;
  logic [CW-1:0] count_q, count_d;
  logic do_push, do_pop;

  assign full_o  = (count_q == CW'(DEPTH));
  assign empty_o = (count_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rptr_q];

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    if (do_push) begin
      wptr_d = (wptr_q == PW'(DEPTH - 1)) ? '0 : wptr_q + 1'b1;
    end
    if (do_pop) begin
      rptr_d = (rptr_q == PW'(DEPTH - 1)) ? '0 : rptr_q + 1'b1;
    end
    unique case ({do_push, do_pop})
      2'b10:   count_d = count_q + 1'b1;
      2'b01:   count_d = count_q - 1'b1;
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      wptr_q  <= wptr_d;
      rptr_q  <= rptr_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= data_i;
    end
  end

endmodule
`default_nettype wire

// ===== src/cpp_front.sv =====
`default_nettype none
module cpp_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push,
  output logic                full,
  input  logic [1:0]          cmd_i,
  input  logic [3:0]          word_index_i,
  input  logic [31:0]         word_value_i,
  input  logic [2:0][2:0][31:0] world_i,
  output logic                work_valid_o,
  output cpp_pkg::work_t      work_o,
  input  logic                work_full_i
);
  logic [31:0] pose_q [cpp_pkg::NUM_POSE];
  logic valid_q, valid_d;
  logic accept, is_item, take;
  cpp_pkg::work_t work_q, work_d;

  assign full    = valid_q && work_full_i;
  assign accept  = push && !full;
  assign is_item = (cmd_i == cpp_pkg::CMD_PROJECT) || (cmd_i == cpp_pkg::CMD_FACING);
  assign take    = valid_q && !work_full_i;

  assign work_valid_o = valid_q;
  assign work_o       = work_q;

  // snapshot of the pose plus saturated world-minus-position differences
  always_comb begin
    work_d.kind = (cmd_i == cpp_pkg::CMD_FACING) ? cpp_pkg::KIND_FACING
                                                 : cpp_pkg::KIND_PROJECT;
    for (int i = 0; i < 9; i++) begin
      work_d.rot[i] = pose_q[i];
    end
    for (int v = 0; v < 3; v++) begin
      for (int j = 0; j < 3; j++) begin
        work_d.d[v][j] = cpp_pkg::sat32(64'($signed(world_i[v][j]))
                         - 64'($signed(pose_q[cpp_pkg::POS_BASE + j])));
      end
    end
    valid_d = valid_q;
    if (accept && is_item) begin
      valid_d = 1'b1;
    end else if (take) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      for (int i = 0; i < cpp_pkg::NUM_POSE; i++) begin
        pose_q[i] <= (i == 0 || i == 4 || i == 8) ? cpp_pkg::ONE_Q16 : 32'h0;
      end
    end else begin
      valid_q <= valid_d;
      if (accept && (cmd_i == cpp_pkg::CMD_LOAD)
          && (word_index_i < 4'(cpp_pkg::NUM_POSE))) begin
        pose_q[word_index_i] <= word_value_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && is_item) begin
      work_q <= work_d;
    end
  end

endmodule
`default_nettype wire

// ===== src/cpp_div.sv =====
`default_nettype none
module cpp_div #(
  parameter int unsigned TAG_W = 1
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          en_i,
  input  logic                          valid_i,
  input  logic [63:0]                   num_i,
  input  logic [30:0]                   den_i,
  input  logic [TAG_W-1:0]              tag_i,
  output logic                          valid_o,
  output logic [cpp_pkg::DIV_STEPS-1:0] quo_o,
  output logic [TAG_W-1:0]              tag_o
);
  localparam int unsigned N = cpp_pkg::DIV_STEPS;

  logic [N-1:0] vld_q;
  logic [30:0]      rem_q [N];
  logic [N-1:0]     quo_q [N];
  logic [N-1:0]     low_q [N];
  logic [30:0]      den_q [N];
  logic [TAG_W-1:0] tag_q [N];

  logic [30:0]      rem_in [N];
  logic [N-1:0]     quo_in [N];
  logic [N-1:0]     low_in [N];
  logic [30:0]      den_in [N];
  logic [TAG_W-1:0] tag_in [N];
  logic [31:0]      trial  [N];
  logic [30:0]      rem_nx [N];
  logic [N-1:0]     quo_nx [N];

  // restoring division, one quotient bit per stage; caller guarantees quotient < 2^N
  always_comb begin
    rem_in[0] = 31'(num_i[63:N]);
    low_in[0] = num_i[N-1:0];
    quo_in[0] = '0;
    den_in[0] = den_i;
    tag_in[0] = tag_i;
    for (int k = 1; k < N; k++) begin
      rem_in[k] = rem_q[k-1];
      low_in[k] = low_q[k-1];
      quo_in[k] = quo_q[k-1];
      den_in[k] = den_q[k-1];
      tag_in[k] = tag_q[k-1];
    end
    for (int k = 0; k < N; k++) begin
      trial[k]  = {rem_in[k], low_in[k][N-1-k]};
      quo_nx[k] = quo_in[k];
      if (trial[k] >= {1'b0, den_in[k]}) begin
        rem_nx[k]          = 31'(trial[k] - {1'b0, den_in[k]});
        quo_nx[k][N-1-k]   = 1'b1;
      end else begin
        rem_nx[k]          = trial[k][30:0];
        quo_nx[k][N-1-k]   = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[N-2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < N; k++) begin
        rem_q[k] <= rem_nx[k];
        quo_q[k] <= quo_nx[k];
        low_q[k] <= low_in[k];
        den_q[k] <= den_in[k];
        tag_q[k] <= tag_in[k];
      end
    end
  end

  assign valid_o = vld_q[N-1];
  assign quo_o   = quo_q[N-1];
  assign tag_o   = tag_q[N-1];

endmodule
`default_nettype wire

// ===== src/cpp_back.sv =====
`default_nettype none
module cpp_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               work_valid_i,
  input  cpp_pkg::work_t     work_i,
  output logic               work_pop_o,
  input  logic [31:0]        focal_x_i,
  input  logic [31:0]        focal_y_i,
  input  logic [31:0]        center_x_i,
  input  logic [31:0]        center_y_i,
  output logic               res_valid_o,
  output cpp_pkg::result_t   res_o,
  input  logic               res_full_i
);
  localparam int unsigned N  = cpp_pkg::DIV_STEPS;
  localparam int unsigned CW = 31 + cpp_pkg::DIV_STEPS;

  typedef struct packed {
    logic        kind;
    logic        bad;
    logic [63:0] magx;
    logic [63:0] magy;
    logic        sx;
    logic        sy;
    logic        ox;
    logic        oy;
    logic [30:0] den;
  } side_t;

  logic adv;
  logic [5:0] vld_q;
  logic [2:0] kind_q;

  // S1: rotation products, floored to Q16.16
  logic signed [63:0] prod_c [3][3][3];
  logic signed [47:0] fl_q   [3][3][3];
  // S2: camera-frame points [vertex][axis]
  logic signed [49:0] sum_c  [3][3];
  logic [31:0]        q_q    [3][3];
  // E1
  logic signed [63:0] m_c [6];
  logic signed [63:0] m_q [6];
  logic signed [64:0] px_c, py_c, px_q, py_q;
  logic [31:0]        qa1_q [3];
  // E2
  logic signed [64:0] cof_c [3];
  logic signed [64:0] cof_q [3];
  logic [31:0]        qa2_q [3];
  logic signed [64:0] negx, negy;
  side_t side_c, side2_q, side3_q, side4_q;
  // E3
  logic signed [64:0] lo_c [3], hi_c [3], lo_q [3], hi_q [3];
  // E4
  logic signed [96:0] term_c [3], term_q [3];
  logic signed [98:0] det_c;

  logic                  vu, vv;
  logic [N-1:0]          quo_u, quo_v;
  logic [4:0]            tag_u;
  logic [1:0]            tag_v;
  logic [31:0]           pix_u, pix_v;

  assign adv        = !res_full_i;
  assign work_pop_o = adv && work_valid_i;

  always_comb begin
    for (int v = 0; v < 3; v++) begin
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          prod_c[v][i][j] = $signed(work_i.d[v][j]) * $signed(work_i.rot[3*j+i]);
        end
        sum_c[v][i] = 50'(fl_q[v][i][0]) + 50'(fl_q[v][i][1]) + 50'(fl_q[v][i][2]);
      end
    end
    // 2x2 minors of vertices b and c
    m_c[0] = $signed(q_q[1][1]) * $signed(q_q[2][2]);
    m_c[1] = $signed(q_q[1][2]) * $signed(q_q[2][1]);
    m_c[2] = $signed(q_q[1][2]) * $signed(q_q[2][0]);
    m_c[3] = $signed(q_q[1][0]) * $signed(q_q[2][2]);
    m_c[4] = $signed(q_q[1][0]) * $signed(q_q[2][1]);
    m_c[5] = $signed(q_q[1][1]) * $signed(q_q[2][0]);
    px_c = $signed({1'b0, focal_x_i}) * $signed(q_q[0][0]);
    py_c = $signed({1'b0, focal_y_i}) * $signed(q_q[0][1]);

    cof_c[0] = 65'(m_q[0]) - 65'(m_q[1]);
    cof_c[1] = 65'(m_q[2]) - 65'(m_q[3]);
    cof_c[2] = 65'(m_q[4]) - 65'(m_q[5]);
    negx = -px_q;
    negy = -py_q;
    side_c.kind = kind_q[2];
    side_c.bad  = qa1_q[2][31] || (qa1_q[2] == 32'h0);
    side_c.sx   = px_q[64];
    side_c.sy   = py_q[64];
    side_c.magx = px_q[64] ? negx[63:0] : px_q[63:0];
    side_c.magy = py_q[64] ? negy[63:0] : py_q[63:0];
    side_c.den  = qa1_q[2][30:0];
    side_c.ox   = CW'(side_c.magx) >= {side_c.den, N'(0)};
    side_c.oy   = CW'(side_c.magy) >= {side_c.den, N'(0)};

    for (int i = 0; i < 3; i++) begin
      lo_c[i]   = $signed(qa2_q[i]) * $signed({1'b0, cof_q[i][31:0]});
      hi_c[i]   = $signed(qa2_q[i]) * $signed(cof_q[i][64:32]);
      term_c[i] = $signed({hi_q[i], 32'h0}) + 97'(lo_q[i]);
    end
    det_c = 99'(term_q[0]) + 99'(term_q[1]) + 99'(term_q[2]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[4:0], work_valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      kind_q <= {kind_q[1:0], work_i.kind};
      for (int v = 0; v < 3; v++) begin
        for (int i = 0; i < 3; i++) begin
          for (int j = 0; j < 3; j++) begin
            fl_q[v][i][j] <= prod_c[v][i][j][63:16];
          end
          q_q[v][i] <= cpp_pkg::sat32(64'(sum_c[v][i]));
        end
      end
      for (int k = 0; k < 6; k++) begin
        m_q[k] <= m_c[k];
      end
      px_q <= px_c;
      py_q <= py_c;
      for (int i = 0; i < 3; i++) begin
        qa1_q[i] <= q_q[0][i];
        qa2_q[i] <= qa1_q[i];
        cof_q[i] <= cof_c[i];
        lo_q[i]  <= lo_c[i];
        hi_q[i]  <= hi_c[i];
        term_q[i] <= term_c[i];
      end
      side2_q <= side_c;
      side3_q <= side2_q;
      side4_q <= side3_q;
    end
  end

  cpp_div #(.TAG_W(5)) u_div_u (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (vld_q[5]),
    .num_i   (side4_q.magx),
    .den_i   (side4_q.den),
    .tag_i   ({side4_q.kind, side4_q.bad, side4_q.sx, side4_q.ox, det_c[98]}),
    .valid_o (vu),
    .quo_o   (quo_u),
    .tag_o   (tag_u)
  );

  cpp_div #(.TAG_W(2)) u_div_v (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (vld_q[5]),
    .num_i   (side4_q.magy),
    .den_i   (side4_q.den),
    .tag_i   ({side4_q.sy, side4_q.oy}),
    .valid_o (vv),
    .quo_o   (quo_v),
    .tag_o   (tag_v)
  );

  // signed quotient, clamped when too big, plus principal point
  function automatic logic [31:0] finish_pix(input logic [31:0] center,
                                             input logic [N-1:0] quo,
                                             input logic neg,
                                             input logic ovf);
    logic [N:0] mag;
    logic signed [63:0] sq;
    mag = ovf ? {1'b1, N'(0)} : {1'b0, quo};
    sq  = neg ? -$signed(64'(mag)) : $signed(64'(mag));
    return cpp_pkg::sat32(sq + $signed(64'(center)));
  endfunction

  assign pix_u = finish_pix(center_x_i, quo_u, tag_u[2], tag_u[1]);
  assign pix_v = finish_pix(center_y_i, quo_v, tag_v[1], tag_v[0]);

  always_comb begin
    res_o.kind    = tag_u[4];
    res_o.pixel_u = 32'h0;
    res_o.pixel_v = 32'h0;
    res_o.faces   = 1'b0;
    res_o.bad     = 1'b0;
    if (tag_u[4] == cpp_pkg::KIND_FACING) begin
      res_o.faces = tag_u[0];
    end else if (tag_u[3]) begin
      res_o.bad = 1'b1;
    end else begin
      res_o.pixel_u = pix_u;
      res_o.pixel_v = pix_v;
    end
  end

  assign res_valid_o = vu && vv;

endmodule
`default_nettype wire

// ===== bench/tb.sv =====
`timescale 1ns / 1ps
module tb;

  // One input word as the sender offers it. pt holds a, b, c world
  // coordinates in x, y, z order.
  typedef struct {
    cpp_pkg::cmd_e cmd;
    logic [3:0]    idx;
    logic [31:0]   val;
    logic [31:0]   pt [9];
  } word_t;

  // Camera model: holds its own copy of pose and intrinsics, works out the
  // result word each accepted input should give, and checks popped words.
  class proj_scoreboard;
    logic signed [31:0] pose [12];
    logic [31:0] fx, fy, ccx, ccy;
    cpp_pkg::result_t pending_q [$];
    int errors;

    function new();
      for (int i = 0; i < 12; i++) begin
        pose[i] = 0;
      end
      pose[0] = cpp_pkg::ONE_Q16;
      pose[4] = cpp_pkg::ONE_Q16;
      pose[8] = cpp_pkg::ONE_Q16;
      fx = cpp_pkg::ONE_Q16;
      fy = cpp_pkg::ONE_Q16;
      ccx = 0;
      ccy = 0;
      errors = 0;
    endfunction

    function void set_reg(logic [7:0] index, logic [31:0] data);
      case (index)
        cpp_pkg::REG_FOCAL_X:  fx = data;
        cpp_pkg::REG_FOCAL_Y:  fy = data;
        cpp_pkg::REG_CENTER_X: ccx = data;
        cpp_pkg::REG_CENTER_Y: ccy = data;
        default: ;
      endcase
    endfunction

    function longint clamp32(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
    endfunction

    // world -> camera frame: q = R^T (w - p), each product floored
    function void to_cam(input logic [31:0] w0, w1, w2,
                         output longint q0, q1, q2);
      longint d [3];
      longint s [3];
      d[0] = clamp32(longint'($signed(w0)) - longint'(pose[cpp_pkg::POS_BASE]));
      d[1] = clamp32(longint'($signed(w1)) - longint'(pose[cpp_pkg::POS_BASE + 1]));
      d[2] = clamp32(longint'($signed(w2)) - longint'(pose[cpp_pkg::POS_BASE + 2]));
      for (int i = 0; i < 3; i++) begin
        s[i] = 0;
        for (int j = 0; j < 3; j++) begin
          s[i] += (longint'(pose[3 * j + i]) * d[j]) >>> 16;
        end
      end
      q0 = clamp32(s[0]);
      q1 = clamp32(s[1]);
      q2 = clamp32(s[2]);
    endfunction

    function logic [31:0] pixel(logic [31:0] focal, longint num, longint z,
                                logic [31:0] center);
      longint q;
      q = (longint'({32'd0, focal}) * num) / z;
      if (q > (64'sd1 <<< 40)) q = 64'sd1 <<< 40;
      if (q < -(64'sd1 <<< 40)) q = -(64'sd1 <<< 40);
      return 32'(clamp32(q + longint'({32'd0, center})));
    endfunction

    function void note(word_t w);
      longint qa [3], qb [3], qc [3];
      logic signed [127:0] a0, a1, a2, b0, b1, b2, c0, c1, c2, acc;
      cpp_pkg::result_t r;
      r = '0;
      case (w.cmd)
        cpp_pkg::CMD_LOAD: begin
          if (w.idx < cpp_pkg::NUM_POSE) pose[w.idx] = w.val;
        end
        cpp_pkg::CMD_PROJECT: begin
          to_cam(w.pt[0], w.pt[1], w.pt[2], qa[0], qa[1], qa[2]);
          r.kind = cpp_pkg::KIND_PROJECT;
          r.bad = (qa[2] <= 0);
          if (!r.bad) begin
            r.pixel_u = pixel(fx, qa[0], qa[2], ccx);
            r.pixel_v = pixel(fy, qa[1], qa[2], ccy);
          end
          pending_q.push_back(r);
        end
        cpp_pkg::CMD_FACING: begin
          to_cam(w.pt[0], w.pt[1], w.pt[2], qa[0], qa[1], qa[2]);
          to_cam(w.pt[3], w.pt[4], w.pt[5], qb[0], qb[1], qb[2]);
          to_cam(w.pt[6], w.pt[7], w.pt[8], qc[0], qc[1], qc[2]);
          a0 = qa[0]; a1 = qa[1]; a2 = qa[2];
          b0 = qb[0]; b1 = qb[1]; b2 = qb[2];
          c0 = qc[0]; c1 = qc[1]; c2 = qc[2];
          // sign of det[a;b;c], exact in 128 bits
          acc = a0 * b1 * c2 - a0 * b2 * c1 - a1 * b0 * c2
              + a1 * b2 * c0 + a2 * b0 * c1 - a2 * b1 * c0;
          r.kind = cpp_pkg::KIND_FACING;
          r.faces = acc[127];
          pending_q.push_back(r);
        end
        default: ;
      endcase
    endfunction

    function void check(cpp_pkg::result_t act);
      cpp_pkg::result_t e;
      if (pending_q.size() == 0) begin
        $display("%0t: unexpected result word kind=%0d", $time, act.kind);
        errors++;
        return;
      end
      e = pending_q.pop_front();
      if (e.kind !== act.kind) begin
        $display("%0t: result_kind exp %0d act %0d", $time, e.kind, act.kind);
        errors++;
      end
      if (e.pixel_u !== act.pixel_u) begin
        $display("%0t: pixel_u exp %h act %h", $time, e.pixel_u, act.pixel_u);
        errors++;
      end
      if (e.pixel_v !== act.pixel_v) begin
        $display("%0t: pixel_v exp %h act %h", $time, e.pixel_v, act.pixel_v);
        errors++;
      end
      if (e.faces !== act.faces) begin
        $display("%0t: faces_camera exp %0d act %0d", $time, e.faces, act.faces);
        errors++;
      end
      if (e.bad !== act.bad) begin
        $display("%0t: depth_invalid exp %0d act %0d", $time, e.bad, act.bad);
        errors++;
      end
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        push = 1'b0;
  logic        full;
  logic [1:0]  cmd_i = cpp_pkg::CMD_NONE;
  logic [3:0]  word_index_i = '0;
  logic [31:0] word_value_i = '0;
  logic [31:0] ax_i = '0, ay_i = '0, az_i = '0;
  logic [31:0] bx_i = '0, by_i = '0, bz_i = '0;
  logic [31:0] cx_world_i = '0, cy_world_i = '0, cz_world_i = '0;
  logic        empty;
  logic        pop = 1'b0;
  logic        result_kind_o;
  logic [31:0] pixel_u_o, pixel_v_o;
  logic        faces_camera_o, depth_invalid_o;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [7:0]  cfg_index_i = '0;
  logic [31:0] cfg_data_i = '0;

  proj_scoreboard sb;
  bit hold_off_req = 0;   // sender asks the receiver for one long stall
  int words_sent = 0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  camera_point_projector_top i_dut (.*);

  // Offer one word; waits until it is accepted. A zero gap keeps push high
  // into the next word so back-to-back streams hit the block.
  task automatic send_word(word_t w);
    int gap;
    gap = $urandom_range(0, 3);
    if ($urandom_range(0, 7) == 0) gap = 0;
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    push <= 1'b1;
    cmd_i <= w.cmd;
    word_index_i <= w.idx;
    word_value_i <= w.val;
    ax_i <= w.pt[0]; ay_i <= w.pt[1]; az_i <= w.pt[2];
    bx_i <= w.pt[3]; by_i <= w.pt[4]; bz_i <= w.pt[5];
    cx_world_i <= w.pt[6]; cy_world_i <= w.pt[7]; cz_world_i <= w.pt[8];
    do @(posedge clk_i); while (full);
    sb.note(w);
    words_sent++;
  endtask

  // leaves valid high; the caller drops it after the last write
  task automatic write_reg(logic [7:0] index, logic [31:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= index;
    cfg_data_i <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.set_reg(index, data);
  endtask

  // drain: all results in, then let the pipe empty out
  task automatic drain();
    push <= 1'b0;
    while (sb.pending_q.size() != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);
  endtask

  task automatic set_intrinsics(logic [31:0] fx, fy, cx, cy);
    write_reg(cpp_pkg::REG_FOCAL_X, fx);
    write_reg(cpp_pkg::REG_FOCAL_Y, fy);
    write_reg(cpp_pkg::REG_CENTER_X, cx);
    write_reg(cpp_pkg::REG_CENTER_Y, cy);
    cfg_valid_i <= 1'b0;
  endtask

  // coordinate mix: mostly scene-sized, some full range and extremes
  function automatic logic [31:0] rand_coord();
    case ($urandom_range(0, 5))
      0: return $urandom;
      1: return $urandom_range(0, 1) ? 32'h7fff_ffff : 32'h8000_0000;
      2: return 32'($signed($urandom_range(0, 1 << 25)) - (1 << 24));
      default: return 32'($signed($urandom_range(0, 64 << 16)) - (32 << 16));
    endcase
  endfunction

  function automatic logic [31:0] rand_rot();
    case ($urandom_range(0, 5))
      0: return $urandom;
      1: return cpp_pkg::ONE_Q16;
      2: return 32'd0;
      default: return 32'($signed($urandom_range(0, 4 << 16)) - (2 << 16));
    endcase
  endfunction

  function automatic word_t make_word(cpp_pkg::cmd_e c);
    word_t w;
    w.cmd = c;
    w.idx = 4'($urandom_range(0, 15));
    w.val = $urandom;
    for (int i = 0; i < 9; i++) w.pt[i] = rand_coord();
    // push vertex a in front of the camera most of the time
    if ($urandom_range(0, 3) != 0) w.pt[2] = $urandom_range(1 << 12, 1 << 22);
    return w;
  endfunction

  function automatic word_t load_word(int idx, logic [31:0] val);
    word_t w;
    w = make_word(cpp_pkg::CMD_LOAD);
    w.idx = 4'(idx);
    w.val = val;
    return w;
  endfunction

  task automatic directed();
    word_t w;
    // projection at reset pose: in front, on the plane, behind
    w = make_word(cpp_pkg::CMD_PROJECT);
    w.pt[0] = 2 << 16; w.pt[1] = -(3 << 16); w.pt[2] = 4 << 16;
    send_word(w);
    w.pt[2] = 0;
    send_word(w);
    w.pt[2] = -(1 << 16);
    send_word(w);
    // tiny depth, huge x: pixels saturate both ways
    w.pt[0] = 32'h7fff_ffff; w.pt[1] = 32'h8000_0000; w.pt[2] = 1;
    send_word(w);
    // all extremes
    for (int i = 0; i < 9; i++) w.pt[i] = 32'h8000_0000;
    send_word(w);
    for (int i = 0; i < 9; i++) w.pt[i] = 32'h7fff_ffff;
    send_word(w);
    // facing: one winding each way
    w = make_word(cpp_pkg::CMD_FACING);
    w.pt = '{0, 0, 4 << 16, 1 << 16, 0, 4 << 16, 0, 1 << 16, 4 << 16};
    send_word(w);
    w.pt = '{0, 0, 4 << 16, 0, 1 << 16, 4 << 16, 1 << 16, 0, 4 << 16};
    send_word(w);
    // degenerate triangle, zero determinant
    w.pt = '{1 << 16, 1 << 16, 1 << 16, 1 << 16, 1 << 16, 1 << 16,
             1 << 16, 1 << 16, 1 << 16};
    send_word(w);
    // unused command and out-of-range pose index are ignored
    send_word(make_word(cpp_pkg::CMD_NONE));
    send_word(load_word(12, 32'h7fff_ffff));
    send_word(load_word(15, 32'h8000_0000));
    // extreme position words, then projection through them
    send_word(load_word(cpp_pkg::POS_BASE, 32'h7fff_ffff));
    send_word(load_word(cpp_pkg::POS_BASE + 2, 32'h8000_0000));
    send_word(make_word(cpp_pkg::CMD_PROJECT));
    send_word(make_word(cpp_pkg::CMD_FACING));
    send_word(load_word(cpp_pkg::POS_BASE, 0));
    send_word(load_word(cpp_pkg::POS_BASE + 2, 0));
  endtask

  // one phase of random traffic: mostly projections and facing tests
  task automatic random_phase(int n);
    int k;
    for (int i = 0; i < n; i++) begin
      k = $urandom_range(0, 19);
      if (k < 2) begin
        send_word(load_word($urandom_range(0, 8), rand_rot()));
      end else if (k < 3) begin
        send_word(load_word($urandom_range(9, 11), rand_coord()));
      end else if (k < 4) begin
        send_word(make_word(cpp_pkg::cmd_e'($urandom_range(0, 1) ? cpp_pkg::CMD_NONE
                                                                  : cpp_pkg::CMD_LOAD)));
      end else if (k < 12) begin
        send_word(make_word(cpp_pkg::CMD_PROJECT));
      end else begin
        send_word(make_word(cpp_pkg::CMD_FACING));
      end
      if (i == n / 2 && !hold_off_req) hold_off_req = 1;
    end
  endtask

  // receiver: random stalls, plus a long hold-off in each random phase so full rises
  initial begin
    int stall;
    cpp_pkg::result_t r;
    @(posedge rst_ni);
    forever begin
      stall = $urandom_range(0, 3);
      if ($urandom_range(0, 7) == 0) stall = 0;
      if (hold_off_req == 1) begin
        hold_off_req = 0;
        stall = 300;
      end
      if (stall > 0) begin
        pop <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      pop <= 1'b1;
      do @(posedge clk_i); while (empty);
      r.kind = result_kind_o;
      r.pixel_u = pixel_u_o;
      r.pixel_v = pixel_v_o;
      r.faces = faces_camera_o;
      r.bad = depth_invalid_o;
      sb.check(r);
    end
  end

  initial begin
    sb = new();
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    set_intrinsics(cpp_pkg::ONE_Q16, cpp_pkg::ONE_Q16, 32'd0, 32'd0);
    directed();
    random_phase(200);
    drain();

    // largest values
    set_intrinsics(32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);
    random_phase(200);
    drain();

    // all zero
    set_intrinsics(32'd0, 32'd0, 32'd0, 32'd0);
    random_phase(150);
    drain();

    // typical camera: 640x480 with focal 500
    set_intrinsics(500 << 16, 500 << 16, 320 << 16, 240 << 16);
    random_phase(250);
    drain();

    set_intrinsics($urandom, $urandom, $urandom, $urandom);
    random_phase(230);
    drain();

    if (sb.errors == 0 && sb.pending_q.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #3_000_000;
    $display("Some tests failed");
    $finish;
  end

endmodule
